>>> rtl/bsfd_pkg.sv
package bsfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 11;
	localparam int unsigned IDX_W  = 3;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_START_BYTE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_END_BYTE    = 3'd1;
	localparam logic [IDX_W-1:0] REG_ESCAPE_BYTE = 3'd2;
	localparam logic [IDX_W-1:0] REG_START_CODE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_END_CODE    = 3'd4;
	localparam logic [IDX_W-1:0] REG_ESCAPE_CODE = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_LENGTH  = 3'd6;

	localparam logic [BYTE_W-1:0] RST_START_BYTE  = 8'h7D;
	localparam logic [BYTE_W-1:0] RST_END_BYTE    = 8'h7E;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE = 8'h7F;
	localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'h00;
	localparam logic [BYTE_W-1:0] RST_END_CODE    = 8'h01;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'h02;
	localparam logic [LEN_W-1:0]  RST_MAX_LENGTH  = 11'd1024;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_FRAME = 2'd1,
		PH_ESC   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] end_byte;
		logic [BYTE_W-1:0] escape_byte;
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] end_code;
		logic [BYTE_W-1:0] escape_code;
		logic [LEN_W-1:0]  max_length;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              frame_end;
		logic [LEN_W-1:0]  frame_length;
		logic              overflow;
		logic              bad_escape;
	} res_t;

endpackage

>>> rtl/bsfd_cfg.sv
module bsfd_cfg
	import bsfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [LEN_W-1:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte  <= RST_START_BYTE;
			cfg_q.end_byte    <= RST_END_BYTE;
			cfg_q.escape_byte <= RST_ESCAPE_BYTE;
			cfg_q.start_code  <= RST_START_CODE;
			cfg_q.end_code    <= RST_END_CODE;
			cfg_q.escape_code <= RST_ESCAPE_CODE;
			cfg_q.max_length  <= RST_MAX_LENGTH;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_BYTE:  cfg_q.start_byte  <= wr_data[BYTE_W-1:0];
				REG_END_BYTE:    cfg_q.end_byte    <= wr_data[BYTE_W-1:0];
				REG_ESCAPE_BYTE: cfg_q.escape_byte <= wr_data[BYTE_W-1:0];
				REG_START_CODE:  cfg_q.start_code  <= wr_data[BYTE_W-1:0];
				REG_END_CODE:    cfg_q.end_code    <= wr_data[BYTE_W-1:0];
				REG_ESCAPE_CODE: cfg_q.escape_code <= wr_data[BYTE_W-1:0];
				REG_MAX_LENGTH:  cfg_q.max_length  <= wr_data;
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/bsfd_core.sv
module bsfd_core
	import bsfd_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 1024
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	// largest limit the length field can express
	localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
	localparam int unsigned CAP     = (MAX_FRAME > LEN_MAX) ? LEN_MAX : MAX_FRAME;
	localparam logic [LEN_W-1:0] CAP_W = LEN_W'(CAP);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  kept_q, kept_d;
	logic              ovf_q, ovf_d;
	logic              esc_q, esc_d;

	logic              emit;
	logic              want_keep;
	logic [BYTE_W-1:0] keep_val;
	logic [LEN_W-1:0]  limit;
	res_t              res_d;
	res_t              res_q;
	logic              res_valid_q;

	assign advance  = valid_s1 && (!res_valid_q || res_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign limit = (cfg.max_length > CAP_W) ? CAP_W : cfg.max_length;

	always_comb begin
		phase_d   = phase_q;
		kept_d    = kept_q;
		ovf_d     = ovf_q;
		esc_d     = esc_q;
		emit      = 1'b0;
		want_keep = 1'b0;
		keep_val  = byte_s1;
		res_d     = '0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == cfg.start_byte) phase_d = PH_FRAME;
			end
			PH_FRAME: begin
				if (byte_s1 == cfg.end_byte) begin
					emit               = 1'b1;
					res_d.frame_end    = 1'b1;
					res_d.frame_length = kept_q;
					phase_d            = PH_HUNT;
					kept_d             = '0;
					ovf_d              = 1'b0;
					esc_d              = 1'b0;
				end else if (byte_s1 == cfg.escape_byte) begin
					phase_d = PH_ESC;
				end else begin
					want_keep = 1'b1;
				end
			end
			PH_ESC: begin
				phase_d = PH_FRAME;
				if (byte_s1 == cfg.start_code) begin
					want_keep = 1'b1;
					keep_val  = cfg.start_byte;
				end else if (byte_s1 == cfg.end_code) begin
					want_keep = 1'b1;
					keep_val  = cfg.end_byte;
				end else if (byte_s1 == cfg.escape_code) begin
					want_keep = 1'b1;
					keep_val  = cfg.escape_byte;
				end else begin
					esc_d = 1'b1;
				end
			end
			default: phase_d = PH_HUNT;
		endcase

		if (want_keep) begin
			if (kept_q >= limit) begin
				ovf_d = 1'b1;
			end else begin
				kept_d             = kept_q + LEN_W'(1);
				emit               = 1'b1;
				res_d.out_byte     = keep_val;
				res_d.frame_length = kept_d;
			end
		end
		// flags as they stood before this byte
		res_d.overflow   = ovf_q;
		res_d.bad_escape = esc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			kept_q      <= '0;
			ovf_q       <= 1'b0;
			esc_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				kept_q      <= kept_d;
				ovf_q       <= ovf_d;
				esc_q       <= esc_d;
				res_valid_q <= emit;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// an end byte in a frame always returns to hunting with a cleared frame
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_FRAME && byte_s1 == cfg.end_byte
		|=> phase_q == PH_HUNT && kept_q == '0 && !ovf_q && !esc_q)
		else $error("frame end did not clear frame state");

	// a held input word is never overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a word");

	// a new result only appears after the decode step ran
	a_res_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> !res_valid_q || $past(res_valid_q && !res_ready))
		else $error("result appeared without a decode step");

	// a frame end result carries a zero data byte
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.frame_end |-> res_q.out_byte == '0)
		else $error("frame end result has nonzero data");

endmodule

>>> rtl/byte_stuffing_frame_decoder_unit.sv
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_tvalid / s_tready       tdata[7:0] in_byte
// m_axis    out        m_tvalid / m_tready       tdata out_byte, frame_length;
//                                                tlast frame_end; tuser flags
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word per cycle sustained while m_tready stays high: a byte is taken
// into the input register, the phase logic decodes it there and, if it gives
// a result, writes the result register.
// Reset restores the default framing bytes, codes and max_length and puts
// the decoder in the hunting phase; no clearing pass is needed.
// A stalled master side holds the result; the input register then holds
// one more word before s_tready drops. cfg_ready is always high.
module byte_stuffing_frame_decoder_unit
	import bsfd_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 1024
)
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] in_byte

	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [7:0] out_byte, [18:8] frame_length, rest zero
	output logic             m_tlast,   // frame_end
	output logic [1:0]       m_tuser,   // [0] overflow, [1] bad_escape

	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res;

	// register file takes a write every cycle
	assign cfg_ready = 1'b1;

	bsfd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register, phase logic and result register
	bsfd_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result word, padding tdata to whole bytes
	assign m_tdata = {5'b0, res.frame_length, res.out_byte};
	assign m_tlast = res.frame_end;
	assign m_tuser = {res.bad_escape, res.overflow};

endmodule

>>> tb/tb_byte_stuffing_frame_decoder_unit.sv
`timescale 1ns / 100ps

module tb_byte_stuffing_frame_decoder_unit;
	import bsfd_pkg::*;

	localparam int unsigned MAX_FRAME = 1024;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;   // no register behind this index
	localparam int MAX_REPORTS = 10;
	localparam int QUIET_LIMIT = 1000;   // cycles with no word moving on any channel
	localparam int LONG_HOLD   = 80;     // receiver hold-off, long enough to back up the input
	localparam int IDLE_GUARD  = 4;      // a word passes the input and result registers; cover a word with no result
	localparam int END_DRAIN   = 8;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_WORDS = 45;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;
	logic              m_tlast;
	logic [1:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [LEN_W-1:0]  cfg_data = '0;

	byte_stuffing_frame_decoder_unit #(.MAX_FRAME(MAX_FRAME)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder mirror: framing registers and per-frame state, advanced on every
	// accepted input word and every accepted register write.
	cfg_t   link_cfg;
	phase_t dec_phase;
	logic [LEN_W-1:0] kept_len;
	logic   ovf_seen;
	logic   esc_err_seen;
	res_t   frame_results[$];

	// Raw bytes waiting for the driver.
	logic [7:0] tx_bytes[$];

	bit in_fire, out_fire, cfg_fire;
	int words_queued, words_taken, cfg_count;
	int data_words, frame_ends, mismatches, quiet_cycles;

	// Traffic shaping knobs, set per phase.
	bit          tx_steady = 1'b1;
	int          tx_burst = 1;
	int          tx_gap = 0;
	logic [15:0] rx_pattern = '1;
	logic [3:0]  rx_slot = '0;
	int          hold_asks, hold_grants, rx_hold_left;

	function automatic res_t make_result(input logic [7:0] b, input logic last);
		res_t r;
		r.out_byte     = b;
		r.frame_end    = last;
		r.frame_length = kept_len;
		r.overflow     = ovf_seen;
		r.bad_escape   = esc_err_seen;
		return r;
	endfunction

	// Keep a data byte unless the frame is already at its length limit,
	// which is max_length capped at MAX_FRAME.
	function automatic void keep_data(input logic [7:0] b);
		logic [LEN_W-1:0] lim;
		lim = (link_cfg.max_length > MAX_FRAME) ? LEN_W'(MAX_FRAME) : link_cfg.max_length;
		if (kept_len >= lim) begin
			ovf_seen = 1'b1;
		end else begin
			kept_len = kept_len + 1'b1;
			frame_results.push_back(make_result(b, 1'b0));
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		case (dec_phase)
			PH_HUNT: begin
				if (b == link_cfg.start_byte)
					dec_phase = PH_FRAME;
			end
			PH_FRAME: begin
				if (b == link_cfg.end_byte) begin
					frame_results.push_back(make_result(8'h00, 1'b1));
					dec_phase    = PH_HUNT;
					kept_len     = '0;
					ovf_seen     = 1'b0;
					esc_err_seen = 1'b0;
				end else if (b == link_cfg.escape_byte) begin
					dec_phase = PH_ESC;
				end else begin
					// a start byte inside a frame lands here as plain data
					keep_data(b);
				end
			end
			PH_ESC: begin
				// code priority: start, then end, then escape; anything else is an error
				if (b == link_cfg.start_code)
					keep_data(link_cfg.start_byte);
				else if (b == link_cfg.end_code)
					keep_data(link_cfg.end_byte);
				else if (b == link_cfg.escape_code)
					keep_data(link_cfg.escape_byte);
				else
					esc_err_seen = 1'b1;
				dec_phase = PH_FRAME;
			end
			default: dec_phase = PH_HUNT;
		endcase
	endfunction

	function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		case (idx)
			REG_START_BYTE:  link_cfg.start_byte  = val[7:0];
			REG_END_BYTE:    link_cfg.end_byte    = val[7:0];
			REG_ESCAPE_BYTE: link_cfg.escape_byte = val[7:0];
			REG_START_CODE:  link_cfg.start_code  = val[7:0];
			REG_END_CODE:    link_cfg.end_code    = val[7:0];
			REG_ESCAPE_CODE: link_cfg.escape_code = val[7:0];
			REG_MAX_LENGTH:  link_cfg.max_length  = val;
			default: ;
		endcase
	endfunction

	// Compare one output word with the oldest pending result.
	function automatic void check_result();
		res_t got, want;
		got.out_byte     = m_tdata[7:0];
		got.frame_length = m_tdata[18:8];
		got.frame_end    = m_tlast;
		got.overflow     = m_tuser[0];
		got.bad_escape   = m_tuser[1];
		if (frame_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: output word with nothing pending: byte=%h last=%b len=%0d flags=%b",
					$time, got.out_byte, got.frame_end, got.frame_length, m_tuser);
		end else begin
			want = frame_results.pop_front();
			if (got !== want || m_tdata[23:19] !== '0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: mismatch exp byte=%h last=%b len=%0d ovf=%b esc=%b",
						$time, want.out_byte, want.frame_end, want.frame_length,
						want.overflow, want.bad_escape);
					$display("%0t:          got byte=%h last=%b len=%0d ovf=%b esc=%b pad=%h",
						$time, got.out_byte, got.frame_end, got.frame_length,
						got.overflow, got.bad_escape, m_tdata[23:19]);
				end
			end
		end
		if (got.frame_end)
			frame_ends++;
		else
			data_words++;
	endfunction

	// Monitor: sample every channel at the rising edge, predict, then check.
	always @(posedge clk) begin
		in_fire  = arst_n && s_tvalid && s_tready;
		out_fire = arst_n && m_tvalid && m_tready;
		cfg_fire = arst_n && cfg_valid && cfg_ready;
		if (cfg_fire) begin
			apply_reg(cfg_index, cfg_data);
			cfg_count++;
		end
		if (in_fire) begin
			decode_byte(s_tdata);
			words_taken++;
		end
		if (out_fire)
			check_result();
		if (in_fire || out_fire || cfg_fire || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// Driver: hold an offered word until taken, then advance in bursts, with gaps when not steady.
	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && !in_fire)) begin
			// hold
		end else if (tx_gap > 0) begin
			tx_gap--;
			s_tvalid <= 1'b0;
		end else if (tx_bytes.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata  <= tx_bytes.pop_front();
			if (tx_burst > 1) begin
				tx_burst--;
			end else begin
				tx_burst = $urandom_range(1, 12);
				tx_gap   = tx_steady ? 0 : $urandom_range(1, 6);
			end
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Receiver: stall on a rotating pattern; honor a long hold-off when asked.
	always @(negedge clk) begin
		if (hold_grants != hold_asks) begin
			hold_grants  = hold_asks;
			rx_hold_left = LONG_HOLD;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= rx_pattern[rx_slot];
		end
		rx_slot = rx_slot + 1'b1;
	end

	// Watchdog: end the run when nothing has moved for too long.
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	task automatic send(input logic [7:0] b);
		tx_bytes.push_back(b);
		words_queued++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		int seen;
		seen = cfg_count;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		while (cfg_count == seen)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Write all seven registers; junk in the upper bits of byte registers must be dropped.
	task automatic write_cfg_set(input logic [7:0] sb, input logic [7:0] eb,
			input logic [7:0] xb, input logic [7:0] sc, input logic [7:0] ec,
			input logic [7:0] xc, input logic [LEN_W-1:0] ml);
		write_reg(REG_START_BYTE,  {3'($urandom), sb});
		write_reg(REG_END_BYTE,    {3'($urandom), eb});
		write_reg(REG_ESCAPE_BYTE, {3'($urandom), xb});
		write_reg(REG_START_CODE,  {3'($urandom), sc});
		write_reg(REG_END_CODE,    {3'($urandom), ec});
		write_reg(REG_ESCAPE_CODE, {3'($urandom), xc});
		write_reg(REG_MAX_LENGTH,  ml);
	endtask

	// Wait until every word has been taken and every result has arrived,
	// then let a word that gives no result clear the pipeline.
	task automatic wait_idle();
		while (words_taken != words_queued || frame_results.size() != 0)
			@(negedge clk);
		repeat (IDLE_GUARD) @(negedge clk);
	endtask

	// Queue one stuffed frame under the current settings: a little noise while
	// hunting, the start byte, n_data data bytes (some escaped, some bad codes),
	// and the end byte unless the frame is left open.
	task automatic queue_frame(input int n_data, input int bad_pct, input bit closed);
		logic [7:0] b;
		int k;
		repeat ($urandom_range(0, 2)) begin
			b = 8'($urandom);
			if (b != link_cfg.start_byte)
				send(b);
		end
		send(link_cfg.start_byte);
		for (k = 0; k < n_data; k++) begin
			b = 8'($urandom);
			if ($urandom_range(99) < bad_pct) begin
				// unknown code, often an end byte right after the escape
				send(link_cfg.escape_byte);
				send($urandom_range(1) ? link_cfg.end_byte : 8'($urandom));
			end else if (b == link_cfg.end_byte || b == link_cfg.escape_byte
					|| $urandom_range(5) == 0) begin
				send(link_cfg.escape_byte);
				if (b == link_cfg.end_byte)
					send(link_cfg.end_code);
				else if (b == link_cfg.escape_byte)
					send(link_cfg.escape_code);
				else begin
					case ($urandom_range(2))
						0: send(link_cfg.start_code);
						1: send(link_cfg.end_code);
						default: send(link_cfg.escape_code);
					endcase
				end
			end else if ($urandom_range(19) == 0) begin
				send(link_cfg.start_byte);
			end else begin
				send(b);
			end
		end
		if (closed)
			send(link_cfg.end_byte);
	endtask

	initial begin
		int phase_no, mark;
		logic [IDX_W-1:0] reg_idx;
		logic [LEN_W-1:0] reg_val;

		link_cfg.start_byte  = RST_START_BYTE;
		link_cfg.end_byte    = RST_END_BYTE;
		link_cfg.escape_byte = RST_ESCAPE_BYTE;
		link_cfg.start_code  = RST_START_CODE;
		link_cfg.end_code    = RST_END_CODE;
		link_cfg.escape_code = RST_ESCAPE_CODE;
		link_cfg.max_length  = RST_MAX_LENGTH;
		dec_phase    = PH_HUNT;
		kept_len     = '0;
		ovf_seen     = 1'b0;
		esc_err_seen = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frame under reset settings: noise while hunting (end and escape
		// bytes included), extreme data, a start byte kept as data, all three
		// escape codes, an end byte after an escape, an unknown code.
		send(8'h00);
		send(8'hFF);
		send(link_cfg.end_byte);
		send(link_cfg.escape_byte);
		send(link_cfg.start_byte);
		send(8'h00);
		send(8'hFF);
		send(link_cfg.start_byte);
		send(link_cfg.escape_byte);
		send(link_cfg.start_code);
		send(link_cfg.escape_byte);
		send(link_cfg.end_code);
		send(link_cfg.escape_byte);
		send(link_cfg.escape_code);
		send(link_cfg.escape_byte);
		send(link_cfg.end_byte);
		send(link_cfg.escape_byte);
		send(8'h55);
		send(8'hAA);
		send(link_cfg.end_byte);
		wait_idle();

		// An out-of-range index must change nothing.
		write_reg(REG_UNUSED, '1);

		// Extreme byte settings with a one-byte limit: a longer frame overflows, then an empty frame.
		write_cfg_set(8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h7F, 11'd1);
		rx_pattern = 16'hA5C3;
		tx_steady  = 1'b0;
		queue_frame(4, 25, 1'b1);
		queue_frame(0, 0, 1'b1);
		wait_idle();

		// Limit of zero drops every data byte.
		write_cfg_set(8'hFF, 8'h00, 8'h01, 8'h80, 8'hFE, 8'h7F, 11'd0);
		queue_frame(3, 0, 1'b1);
		wait_idle();

		// Random phases: a few register writes, then well-formed frames with random
		// content, some bad codes and some frames left open.
		for (phase_no = 0; phase_no < RAND_PHASES; phase_no++) begin
			wait_idle();
			repeat ($urandom_range(1, 3)) begin
				reg_idx = IDX_W'($urandom_range(7));
				reg_val = LEN_W'($urandom);
				if (reg_idx == REG_MAX_LENGTH) begin
					case ($urandom_range(7))
						0: reg_val = 11'd0;
						1: reg_val = 11'd1;
						2: reg_val = 11'd1024;
						3: reg_val = 11'd2047;
						4: reg_val = LEN_W'($urandom);
						default: reg_val = LEN_W'($urandom_range(2, 10));
					endcase
				end
				write_reg(reg_idx, reg_val);
			end
			rx_pattern = ($urandom_range(3) == 0) ? '1 : (16'($urandom) | 16'h0001);
			tx_steady  = ($urandom_range(3) == 0);
			mark = words_queued;
			while (words_queued - mark < PHASE_WORDS)
				queue_frame($urandom_range(0, 8), 8, $urandom_range(9) != 0);
		end

		// Back-pressure: block the receiver for a long stretch while the sender
		// keeps offering, then pause the sender until every result is out.
		wait_idle();
		write_cfg_set(RST_START_BYTE, RST_END_BYTE, RST_ESCAPE_BYTE, RST_START_CODE,
			RST_END_CODE, RST_ESCAPE_CODE, RST_MAX_LENGTH);
		rx_pattern = '1;
		tx_steady  = 1'b1;
		repeat (6) queue_frame(8, 0, 1'b1);
		hold_asks++;
		wait_idle();

		// A limit above MAX_FRAME still keeps a short frame whole.
		write_reg(REG_MAX_LENGTH, 11'd2047);
		rx_pattern = 16'($urandom) | 16'h8001;
		tx_steady  = 1'b0;
		queue_frame(12, 0, 1'b1);

		wait_idle();
		repeat (END_DRAIN) @(negedge clk);
		$display("Run: %0d input words, %0d data, %0d frame ends, %0d register writes.",
			words_taken, data_words, frame_ends, cfg_count);
		$display("Included extreme framing bytes, zero and oversized limits, and a long receiver stall.");
		if (mismatches == 0 && frame_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/bsfd_pkg.sv
rtl/bsfd_cfg.sv
rtl/bsfd_core.sv
rtl/byte_stuffing_frame_decoder_unit.sv
tb/tb_byte_stuffing_frame_decoder_unit.sv
